>>> hdl/fbsp_pkg.sv
// Shared types and constants for the frame buffer slot pool.
package fbsp_pkg;

   localparam int SLOTS_DEFAULT = 16;
   localparam int FREE_COUNT_MAX = 31;

   localparam logic [2:0] CMD_TAKE_FREE     = 3'd0;
   localparam logic [2:0] CMD_TAKE_CAPTURED = 3'd1;
   localparam logic [2:0] CMD_RESET_POOL    = 3'd2;
   localparam logic [2:0] CMD_COUNT_FREE    = 3'd3;
   localparam logic [2:0] CMD_SET_STATE     = 3'd4;

   localparam logic [2:0] SLOT_FREE     = 3'd0;
   localparam logic [2:0] SLOT_HELD     = 3'd1;
   localparam logic [2:0] SLOT_CAPTURED = 3'd2;
   localparam logic [2:0] SLOT_STORING  = 3'd3;
   localparam logic [2:0] SLOT_UNUSABLE = 3'd4;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_SCAN,
      FSM_DONE
   } fsm_type;

endpackage

>>> hdl/frame_buffer_slot_pool_unit.sv
// Top level of the frame buffer slot pool: slot state RAM, scan sequencer and result register.
//
// The pool keeps a state code for each of SLOTS slots in a RAM with a registered read. Take,
// reset-pool and count commands walk the RAM one slot per cycle through its single read port:
// a take that matches stops at the matching slot, while a take that misses, a reset pool and a
// count read all SLOTS slots; set state and an unknown command skip the scan. One command is
// worked on at a time, and the next one is accepted only after the result is loaded. A new
// command is accepted while the previous result still waits in the result register. After
// reset every slot reads as free through per-slot valid flags, so the block accepts commands
// at once with no clearing pass.
module frame_buffer_slot_pool_unit #(
   parameter int SLOTS = fbsp_pkg::SLOTS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // command[2:0], slot[6:3], new_state[9:7], zero fill
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata   // found[0], slot_index[4:1], free_count[9:5], zero fill
);

   import fbsp_pkg::*;

   localparam int IW = $clog2(SLOTS);
   localparam int CW = $clog2(SLOTS + 1);

   logic [2:0] req_command;
   logic [3:0] req_slot;
   logic [2:0] req_new_state;
   logic       req_accept;

   fsm_type fsm_ff, fsm_in;

   logic [2:0]    cmd_ff, cmd_in;
   logic [IW-1:0] ptr_free_ff, ptr_free_in;
   logic [IW-1:0] ptr_cap_ff, ptr_cap_in;
   logic [IW-1:0] start_ff, start_in;
   logic [IW-1:0] addr_ff, addr_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] free_ff, free_in;
   logic          rd_vld_ff, rd_vld_in;
   logic          rd_last_ff, rd_last_in;
   logic [IW-1:0] rd_addr_ff, rd_addr_in;
   logic [SLOTS-1:0] vld_ff, vld_in;

   logic          res_found_ff, res_found_in;
   logic [IW-1:0] res_idx_ff, res_idx_in;
   logic          rsp_tvalid_ff, rsp_tvalid_in;
   logic [15:0]   rsp_tdata_ff, rsp_tdata_in;

   logic          ram_we;
   logic [IW-1:0] ram_waddr;
   logic [2:0]    ram_wdata;
   logic          ram_re;
   logic [2:0]    ram_q;
   logic [2:0]    rd_state;
   logic          issue;
   logic          hit;
   logic [2:0]    want_code;
   logic [2:0]    mark_code;
   logic [IW+3:0] slot_ext;
   logic [IW+3:0] idx_ext;
   logic [CW+4:0] free_ext;
   logic [4:0]    free_sat;
   logic          out_free;

   assign req_command   = req_tdata[2:0];
   assign req_slot      = req_tdata[6:3];
   assign req_new_state = req_tdata[9:7];
   assign req_tready    = (fsm_ff == FSM_IDLE);
   assign req_accept    = req_tvalid && req_tready;
   assign out_free      = !rsp_tvalid_ff || rsp_tready;

   assign rd_state  = vld_ff[rd_addr_ff] ? ram_q : SLOT_FREE;
   assign want_code = (cmd_ff == CMD_TAKE_FREE) ? SLOT_FREE : SLOT_CAPTURED;
   assign mark_code = (cmd_ff == CMD_TAKE_FREE) ? SLOT_HELD : SLOT_STORING;
   assign issue     = (fsm_ff == FSM_SCAN) && (cnt_ff != CW'(SLOTS));
   assign hit       = (fsm_ff == FSM_SCAN) && rd_vld_ff && rd_state == want_code
                      && (cmd_ff == CMD_TAKE_FREE || cmd_ff == CMD_TAKE_CAPTURED);
   assign slot_ext  = (IW + 4)'(req_slot);
   assign ram_re    = issue;

   fbsp_ram #(
      .WIDTH(3),
      .DEPTH(SLOTS)
   ) u_state_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_en  (ram_re),
      .rd_addr(addr_ff),
      .rd_data(ram_q)
   );

   always_comb begin
      fsm_in = fsm_ff;
      case (fsm_ff)
         FSM_IDLE: begin
            if (req_accept) begin
               case (req_command)
                  CMD_TAKE_FREE, CMD_TAKE_CAPTURED, CMD_RESET_POOL, CMD_COUNT_FREE: begin
                     fsm_in = FSM_SCAN;
                  end
                  default: begin
                     fsm_in = FSM_DONE;
                  end
               endcase
            end
         end
         FSM_SCAN: begin
            if (hit || (rd_vld_ff && rd_last_ff)) begin
               fsm_in = FSM_DONE;
            end
         end
         FSM_DONE: begin
            if (out_free) begin
               fsm_in = FSM_IDLE;
            end
         end
         default: begin
            fsm_in = FSM_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd_in        = cmd_ff;
      ptr_free_in   = ptr_free_ff;
      ptr_cap_in    = ptr_cap_ff;
      start_in      = start_ff;
      addr_in       = addr_ff;
      cnt_in        = cnt_ff;
      free_in       = free_ff;
      rd_vld_in     = issue;
      rd_last_in    = issue && (cnt_ff == CW'(SLOTS - 1));
      rd_addr_in    = addr_ff;
      vld_in        = vld_ff;
      res_found_in  = res_found_ff;
      res_idx_in    = res_idx_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      ram_we        = 1'b0;
      ram_waddr     = rd_addr_ff;
      ram_wdata     = SLOT_FREE;
      idx_ext       = (IW + 4)'(res_idx_ff);
      free_ext      = (CW + 5)'(free_ff);
      free_sat      = (32'(free_ff) > FREE_COUNT_MAX) ? 5'(FREE_COUNT_MAX) : free_ext[4:0];

      case (fsm_ff)
         FSM_IDLE: begin
            if (req_accept) begin
               cmd_in       = req_command;
               cnt_in       = '0;
               free_in      = '0;
               res_found_in = 1'b0;
               res_idx_in   = '0;
               case (req_command)
                  CMD_TAKE_FREE: begin
                     start_in = ptr_free_ff;
                     addr_in  = ptr_free_ff;
                  end
                  CMD_TAKE_CAPTURED: begin
                     start_in = ptr_cap_ff;
                     addr_in  = ptr_cap_ff;
                  end
                  default: begin
                     start_in = '0;
                     addr_in  = '0;
                  end
               endcase
               if (req_command == CMD_SET_STATE && 32'(req_slot) < SLOTS) begin
                  ram_we    = 1'b1;
                  ram_waddr = slot_ext[IW-1:0];
                  ram_wdata = req_new_state;
                  vld_in[slot_ext[IW-1:0]] = 1'b1;
               end
            end
         end
         FSM_SCAN: begin
            if (issue) begin
               addr_in = (addr_ff == IW'(SLOTS - 1)) ? '0 : addr_ff + 1'b1;
               cnt_in  = cnt_ff + 1'b1;
            end
            if (rd_vld_ff) begin
               case (cmd_ff)
                  CMD_TAKE_FREE, CMD_TAKE_CAPTURED: begin
                     if (hit) begin
                        ram_we       = 1'b1;
                        ram_wdata    = mark_code;
                        vld_in[rd_addr_ff] = 1'b1;
                        res_found_in = 1'b1;
                        res_idx_in   = rd_addr_ff;
                        if (cmd_ff == CMD_TAKE_FREE) begin
                           ptr_free_in = (start_ff == IW'(SLOTS - 1)) ? '0 : start_ff + 1'b1;
                        end else begin
                           ptr_cap_in = (start_ff == IW'(SLOTS - 1)) ? '0 : start_ff + 1'b1;
                        end
                     end
                  end
                  CMD_RESET_POOL: begin
                     if (rd_state != SLOT_UNUSABLE) begin
                        ram_we    = 1'b1;
                        ram_wdata = SLOT_FREE;
                        vld_in[rd_addr_ff] = 1'b1;
                     end
                  end
                  CMD_COUNT_FREE: begin
                     if (rd_state == SLOT_FREE) begin
                        free_in = free_ff + 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         FSM_DONE: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {6'd0, free_sat, idx_ext[3:0], res_found_ff};
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff        <= FSM_IDLE;
         ptr_free_ff   <= '0;
         ptr_cap_ff    <= '0;
         cnt_ff        <= '0;
         rd_vld_ff     <= 1'b0;
         rd_last_ff    <= 1'b0;
         vld_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         fsm_ff        <= fsm_in;
         ptr_free_ff   <= ptr_free_in;
         ptr_cap_ff    <= ptr_cap_in;
         cnt_ff        <= cnt_in;
         rd_vld_ff     <= rd_vld_in;
         rd_last_ff    <= rd_last_in;
         vld_ff        <= vld_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      start_ff     <= start_in;
      addr_ff      <= addr_in;
      free_ff      <= free_in;
      rd_addr_ff   <= rd_addr_in;
      res_found_ff <= res_found_in;
      res_idx_ff   <= res_idx_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   assert property (@(posedge clock) disable iff (reset)
      32'(ptr_free_ff) < SLOTS && 32'(ptr_cap_ff) < SLOTS)
      else $error("Take pointer left the slot range.");

   assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (fsm_ff == FSM_IDLE || fsm_ff == FSM_SCAN))
      else $error("State RAM written outside idle or scan.");

   assert property (@(posedge clock) disable iff (reset)
      (fsm_ff == FSM_SCAN) |-> (free_ff <= cnt_ff))
      else $error("Free count exceeds the number of slots read.");

   assert property (@(posedge clock) disable iff (reset)
      hit |=> (fsm_ff == FSM_DONE && res_found_ff))
      else $error("Take hit did not close the scan.");

endmodule

>>> hdl/fbsp_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module fbsp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> tb/frame_buffer_slot_pool_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the frame buffer slot pool: predicted results compared word by word.
module frame_buffer_slot_pool_unit_tb;
   import fbsp_pkg::*;

   localparam int POOL_SLOTS = SLOTS_DEFAULT;
   localparam logic [2:0] CMD_UNUSED_LAST = 3'd7;
   localparam int CYCLE_LIMIT = 800000;
   localparam int DRAIN_CYCLES = 40;
   localparam int REPORT_LINES_MAX = 60;

   typedef struct packed {
      logic [2:0] new_state;
      logic [3:0] slot;
      logic [2:0] command;
   } pool_cmd_type;

   typedef struct packed {
      logic [4:0] free_count;
      logic [3:0] slot_index;
      logic       found;
   } pool_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;  // command[2:0], slot[6:3], new_state[9:7], zero fill
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;       // found[0], slot_index[4:1], free_count[9:5], zero fill

   logic [2:0]      model_slot_state [POOL_SLOTS];
   logic [3:0]      model_free_ptr = '0;
   logic [3:0]      model_captured_ptr = '0;
   pool_result_type pool_results_due [$];

   int mismatch_count = 0;
   int cycle_count = 0;
   bit quiet_tail = 1'b0;
   int hold_off_len = 0;
   int hold_off_seq = 0;
   int hold_off_seen = 0;
   int hold_off_left = 0;
   int rx_stall_left = 0;

   frame_buffer_slot_pool_unit #(
      .SLOTS(POOL_SLOTS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   always #4 clock = ~clock;

   initial begin
      for (int i = 0; i < POOL_SLOTS; i++) begin
         model_slot_state[i] = SLOT_FREE;
      end
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      if (mismatch_count < REPORT_LINES_MAX) begin
         $display("MISMATCH at cycle %0d, %s: got %0d, expected %0d", cycle_count, what, got, want);
      end
      mismatch_count++;
   endtask

   task automatic take_matching(input logic [2:0] want, input logic [2:0] mark,
                                inout logic [3:0] ptr, output pool_result_type res);
      logic [3:0] k;
      res = '0;
      for (int i = 0; i < POOL_SLOTS; i++) begin
         k = ptr + i[3:0];
         if (!res.found && model_slot_state[k] == want) begin
            model_slot_state[k] = mark;
            res.found = 1'b1;
            res.slot_index = k;
         end
      end
      if (res.found) begin
         ptr = ptr + 4'd1;
      end
   endtask

   task automatic apply_pool_command(input pool_cmd_type cmd);
      pool_result_type res;
      int free_slots;
      res = '0;
      free_slots = 0;
      case (cmd.command)
         CMD_TAKE_FREE: begin
            take_matching(SLOT_FREE, SLOT_HELD, model_free_ptr, res);
         end
         CMD_TAKE_CAPTURED: begin
            take_matching(SLOT_CAPTURED, SLOT_STORING, model_captured_ptr, res);
         end
         CMD_RESET_POOL: begin
            for (int i = 0; i < POOL_SLOTS; i++) begin
               if (model_slot_state[i] != SLOT_UNUSABLE) begin
                  model_slot_state[i] = SLOT_FREE;
               end
            end
         end
         CMD_COUNT_FREE: begin
            for (int i = 0; i < POOL_SLOTS; i++) begin
               if (model_slot_state[i] == SLOT_FREE) begin
                  free_slots++;
               end
            end
            if (free_slots > FREE_COUNT_MAX) begin
               free_slots = FREE_COUNT_MAX;
            end
            res.free_count = free_slots[4:0];
         end
         CMD_SET_STATE: begin
            if (cmd.slot < POOL_SLOTS) begin
               model_slot_state[cmd.slot] = cmd.new_state;
            end
         end
         default: begin
         end
      endcase
      pool_results_due.push_back(res);
   endtask

   task automatic send_pool_command(input logic [2:0] command, input logic [3:0] slot,
                                    input logic [2:0] new_state);
      pool_cmd_type cmd;
      cmd.command = command;
      cmd.slot = slot;
      cmd.new_state = new_state;
      if (!quiet_tail && $urandom_range(0, 5) == 0) begin
         repeat ($urandom_range(1, 19)) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
         end
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= {6'b0, cmd};
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      apply_pool_command(cmd);
   endtask

   task automatic release_request();
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   task automatic wait_for_results();
      while (pool_results_due.size() != 0) begin
         @(posedge clock);
      end
   endtask

   function automatic int pick_slot_in(input logic [2:0] want);
      int start;
      int k;
      start = $urandom_range(0, POOL_SLOTS - 1);
      for (int i = 0; i < POOL_SLOTS; i++) begin
         k = (start + i) % POOL_SLOTS;
         if (model_slot_state[k] == want) begin
            return k;
         end
      end
      return -1;
   endfunction

   // Most words follow the slot life cycle: take free, capture done, take captured, store done.
   task automatic send_random_command();
      logic [2:0] command;
      logic [3:0] slot;
      logic [2:0] new_state;
      int r;
      int pick;
      command = CMD_SET_STATE;
      slot = 4'($urandom_range(0, POOL_SLOTS - 1));
      new_state = 3'($urandom_range(0, 7));
      r = $urandom_range(0, 99);
      if (r < 22) begin
         command = CMD_TAKE_FREE;
      end else if (r < 40) begin
         command = CMD_TAKE_CAPTURED;
      end else if (r < 52) begin
         pick = pick_slot_in(SLOT_HELD);
         if (pick >= 0) slot = 4'(pick);
         new_state = SLOT_CAPTURED;
      end else if (r < 64) begin
         pick = pick_slot_in(SLOT_STORING);
         if (pick >= 0) slot = 4'(pick);
         new_state = SLOT_FREE;
      end else if (r < 70) begin
         new_state = $urandom_range(0, 1) ? SLOT_UNUSABLE : SLOT_FREE;
      end else if (r < 80) begin
         command = CMD_COUNT_FREE;
      end else if (r < 83) begin
         command = CMD_RESET_POOL;
      end else if (r < 88) begin
         command = 3'($urandom_range(CMD_SET_STATE + 1, CMD_UNUSED_LAST));
      end else begin
         command = 3'($urandom_range(0, 7));
      end
      send_pool_command(command, slot, new_state);
   endtask

   task automatic test_directed_cases();
      send_pool_command(CMD_COUNT_FREE, 4'd0, SLOT_FREE);
      send_pool_command(CMD_TAKE_CAPTURED, 4'd0, SLOT_FREE);
      send_pool_command(CMD_TAKE_FREE, 4'd0, SLOT_FREE);
      send_pool_command(CMD_TAKE_FREE, 4'd15, 3'd7);
      send_pool_command(CMD_SET_STATE, 4'd1, SLOT_CAPTURED);
      send_pool_command(CMD_TAKE_CAPTURED, 4'd0, SLOT_FREE);
      send_pool_command(CMD_SET_STATE, 4'd15, SLOT_UNUSABLE);
      send_pool_command(CMD_SET_STATE, 4'd0, 3'd7);
      send_pool_command(CMD_COUNT_FREE, 4'd15, 3'd7);
      send_pool_command(CMD_RESET_POOL, 4'd15, 3'd7);
      send_pool_command(CMD_COUNT_FREE, 4'd0, SLOT_FREE);
      send_pool_command(CMD_TAKE_CAPTURED, 4'd15, 3'd7);
      for (int c = CMD_SET_STATE + 1; c <= CMD_UNUSED_LAST; c++) begin
         send_pool_command(c[2:0], 4'd15, 3'd7);
      end
      send_pool_command(CMD_SET_STATE, 4'd15, SLOT_FREE);
      send_pool_command(CMD_SET_STATE, 4'd0, SLOT_UNUSABLE);
      send_pool_command(CMD_TAKE_FREE, 4'd0, SLOT_FREE);
      send_pool_command(CMD_COUNT_FREE, 4'd0, SLOT_FREE);
      send_pool_command(CMD_SET_STATE, 4'd0, SLOT_FREE);
      send_pool_command(CMD_RESET_POOL, 4'd0, SLOT_FREE);
   endtask

   // Takes every slot, then misses on a full pool, then frees it again.
   task automatic test_full_pool();
      for (int i = 0; i <= POOL_SLOTS; i++) begin
         send_pool_command(CMD_TAKE_FREE, 4'd0, SLOT_FREE);
      end
      send_pool_command(CMD_COUNT_FREE, 4'd0, SLOT_FREE);
      send_pool_command(CMD_RESET_POOL, 4'd0, SLOT_FREE);
   endtask

   task automatic test_random_traffic(input int words);
      repeat (words) send_random_command();
   endtask

   // The receiver holds off long enough that the block stops accepting words.
   task automatic test_input_backpressure();
      hold_off_len = 400;
      hold_off_seq++;
      repeat (12) begin
         send_pool_command(CMD_TAKE_FREE, 4'd0, SLOT_FREE);
      end
      test_random_traffic(20);
   endtask

   task automatic test_drain_pause();
      release_request();
      wait_for_results();
      test_random_traffic(30);
   endtask

   task automatic test_quiet_tail(input int words);
      quiet_tail = 1'b1;
      test_random_traffic(words);
   endtask

   always @(negedge clock) begin
      if (hold_off_seq != hold_off_seen) begin
         hold_off_seen = hold_off_seq;
         hold_off_left = hold_off_len;
      end
      if (hold_off_left > 0) begin
         hold_off_left--;
         rsp_tready <= 1'b0;
      end else if (rx_stall_left > 0) begin
         rx_stall_left--;
         rsp_tready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 11) == 0) begin
         rx_stall_left = $urandom_range(1, 19) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      pool_result_type got;
      pool_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[9:0];
         if (pool_results_due.size() == 0) begin
            report_mismatch("unexpected word", rsp_tdata, 0);
         end else begin
            want = pool_results_due.pop_front();
            if (got.found != want.found) report_mismatch("found", got.found, want.found);
            if (got.slot_index != want.slot_index) begin
               report_mismatch("slot_index", got.slot_index, want.slot_index);
            end
            if (got.free_count != want.free_count) begin
               report_mismatch("free_count", got.free_count, want.free_count);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_full_pool();
      test_random_traffic(700);
      test_input_backpressure();
      test_drain_pause();
      test_random_traffic(750);
      test_quiet_tail(250);
      release_request();
      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pool_results_due.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
